FILE: rtl/core/ptm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm4_pkg
// Shared types, constants and the divider step for the point transform.
// ----------------------------------------------------------------------------
package ptm4_pkg;

	localparam int WORD_W        = 32;
	localparam int NUM_PAIRS     = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_STEPS     = WORD_W;
	localparam int ADDR_W        = 6;

	localparam logic [63:0] MAT_RESET [NUM_PAIRS] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

	typedef struct packed {
		logic              wzero;
		logic              wclip;
		logic [WORD_W-1:0] wmag;
	} side_t;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] nq;
	} lane_t;

	// One restoring step: the next dividend bit moves into the remainder
	// and the quotient bit shifts into the freed low end of nq.
	function automatic lane_t div_step(input lane_t a, input logic [WORD_W-1:0] d);
		lane_t         r;
		logic [WORD_W:0] t;
		r = a;
		t = {a.rem, a.nq[WORD_W-1]};
		if (t >= {1'b0, d}) begin
			r.rem = WORD_W'(t - {1'b0, d});
			r.nq  = {a.nq[WORD_W-2:0], 1'b1};
		end else begin
			r.rem = t[WORD_W-1:0];
			r.nq  = {a.nq[WORD_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/ptm4_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm4_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptm4_div import ptm4_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  side_t           side_in,
	input  lane_t [2:0]     lane_in,
	output logic            out_valid,
	output side_t           side_out,
	output lane_t [2:0]     lane_out
);

	logic [DIV_STEPS-1:0] v_s;
	side_t                side_s [DIV_STEPS];
	lane_t [2:0]          lane_s [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int l = 0; l < 3; l++) begin
				lane_s[0][l] <= div_step(lane_in[l], side_in.wmag);
			end
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < 3; l++) begin
					lane_s[k][l] <= div_step(lane_s[k-1][l], side_s[k-1].wmag);
				end
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS-1];
	assign side_out  = side_s[DIV_STEPS-1];
	assign lane_out  = lane_s[DIV_STEPS-1];

endmodule

FILE: rtl/core/point_transform_mat4_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_transform_mat4_divide
// Transforms a Q16.16 point by a column-major 4x4 matrix and divides by w.
//
// Channel   Direction  Content
// s_*       in         px, py, pz (tdata, 96 bits)
// m_*       out        qx, qy, qz (tdata); w_was_zero, clipped (tuser)
// APB       in/out     eight 64-bit matrix pair registers at 8*i
//
// The pipeline runs multiply, two adds, w scaling, magnitude setup,
// 32 divider stages, output register. One point is taken every cycle unless m_tready stalls the output.
// Reset loads the identity matrix and empties the pipeline.
// The whole pipeline holds while a result waits on m_tready.
// ----------------------------------------------------------------------------
module point_transform_mat4_divide import ptm4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [95:0]       s_tdata,   // px, py, pz
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [95:0]       m_tdata,   // qx, qy, qz
	output logic [1:0]        m_tuser,   // w_was_zero, clipped
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	localparam int SUM_W = 66;
	localparam logic [WORD_W-1:0] ONE_W = WORD_W'(1) << FRAC_BITS;

	logic [63:0] mat_q [NUM_PAIRS];
	logic        adv;

	assign pready = 1'b1;
	assign prdata = mat_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAIRS; i++) mat_q[i] <= MAT_RESET[i];
		end else if (psel && penable && pwrite && pready) begin
			mat_q[paddr[5:3]] <= pwdata;
		end
	end

	logic signed [WORD_W-1:0] wd [16];
	logic signed [WORD_W-1:0] pt [3];

	always_comb begin
		for (int k = 0; k < NUM_PAIRS; k++) begin
			wd[2*k]   = mat_q[k][31:0];
			wd[2*k+1] = mat_q[k][63:32];
		end
		for (int c = 0; c < 3; c++) pt[c] = s_tdata[32*c +: 32];
	end

	logic                 out_valid_q;
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic signed [63:0]      prod_s1 [4][3];
	logic signed [WORD_W-1:0] trans_s1 [4];
	logic signed [64:0]      pa_s2 [4];
	logic signed [64:0]      pb_s2 [4];
	logic signed [SUM_W-1:0] sum_s3 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= wd[4*c+r] * pt[c];
				end
				trans_s1[r] <= wd[12+r];
				pa_s2[r] <= 65'(prod_s1[r][0]) + 65'(prod_s1[r][1]);
				pb_s2[r] <= 65'(prod_s1[r][2]) + (65'(trans_s1[r]) <<< FRAC_BITS);
				sum_s3[r] <= SUM_W'(pa_s2[r]) + SUM_W'(pb_s2[r]);
			end
		end
	end

	// w scaling with saturation and zero substitution; numerator magnitudes.
	logic signed [SUM_W-1:0] wsh;
	logic                    wfits;
	logic [WORD_W-1:0]       wsat;
	logic [SUM_W-1:0]        nneg_v [3];

	always_comb begin
		wsh   = sum_s3[3] >>> FRAC_BITS;
		wfits = (&wsh[SUM_W-1:WORD_W-1]) || !(|wsh[SUM_W-1:WORD_W-1]);
		if (wfits) begin
			wsat = wsh[WORD_W-1:0];
		end else begin
			wsat = wsh[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		for (int r = 0; r < 3; r++) nneg_v[r] = -sum_s3[r];
	end

	logic [WORD_W-1:0] w_s4;
	logic              wzero_s4, wclip_s4;
	logic              nneg_s4 [3];
	logic [63:0]       nmag_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			wzero_s4 <= (wsat == '0);
			wclip_s4 <= !wfits;
			w_s4     <= (wsat == '0) ? ONE_W : wsat;
			for (int r = 0; r < 3; r++) begin
				nneg_s4[r] <= sum_s3[r][SUM_W-1];
				nmag_s4[r] <= sum_s3[r][SUM_W-1] ? nneg_v[r][63:0] : sum_s3[r][63:0];
			end
		end
	end

	logic [WORD_W-1:0] wmag_v;
	assign wmag_v = w_s4[WORD_W-1] ? (~w_s4 + WORD_W'(1)) : w_s4;

	side_t       side_s5;
	lane_t [2:0] lane_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5.wzero <= wzero_s4;
			side_s5.wclip <= wclip_s4;
			side_s5.wmag  <= wmag_v;
			for (int r = 0; r < 3; r++) begin
				lane_s5[r].neg <= nneg_s4[r] ^ w_s4[WORD_W-1];
				lane_s5[r].ovf <= nmag_s4[r][63:32] >= wmag_v;
				lane_s5[r].rem <= nmag_s4[r][63:32];
				lane_s5[r].nq  <= nmag_s4[r][31:0];
			end
		end
	end

	logic        div_valid;
	side_t       div_side;
	lane_t [2:0] div_lane;

	ptm4_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.side_in   (side_s5),
		.lane_in   (lane_s5),
		.out_valid (div_valid),
		.side_out  (div_side),
		.lane_out  (div_lane)
	);

	logic [95:0]       res_v;
	logic              clip_v;
	logic [WORD_W-1:0] q;

	always_comb begin
		clip_v = div_side.wclip;
		res_v  = '0;
		for (int l = 0; l < 3; l++) begin
			q = div_lane[l].nq;
			if (div_lane[l].ovf) begin
				clip_v = 1'b1;
				res_v[32*l +: 32] = div_lane[l].neg ? 32'h8000_0000 : 32'h7fff_ffff;
			end else if (div_lane[l].neg) begin
				if (q > 32'h8000_0000) begin
					clip_v = 1'b1;
					res_v[32*l +: 32] = 32'h8000_0000;
				end else begin
					res_v[32*l +: 32] = ~q + WORD_W'(1);
				end
			end else if (q[WORD_W-1]) begin
				clip_v = 1'b1;
				res_v[32*l +: 32] = 32'h7fff_ffff;
			end else begin
				res_v[32*l +: 32] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= res_v;
			m_tuser <= {clip_v, div_side.wzero};
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
